@@ design/iasort_pkg.sv @@
// ----------------------------------------------------------------------------
// iasort_pkg
// Shared types and constants for the integer array sorter: request
// structs, partition range type and sequencer states.
// ----------------------------------------------------------------------------
package iasort_pkg;

  localparam int CAPACITY    = 64;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int STACK_DEPTH = CAPACITY;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_result;
    logic                     truncated;
  } out_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_POP_RD,
    S_POP,
    S_PIV,
    S_PIV2,
    S_SCAN_RD,
    S_CMP,
    S_SWAP2,
    S_FIN_RD,
    S_FIN,
    S_FIN2,
    S_PUSH_L,
    S_PUSH_R,
    S_OUT_RD,
    S_OUT
  } state_t;

endpackage

@@ design/iasort_ram.sv @@
// ----------------------------------------------------------------------------
// iasort_ram
// Generic memory with one write port and two read ports, read data
// registered and held while the read enable is low.
// ----------------------------------------------------------------------------
module iasort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re0,
  input  logic [ADDR_W-1:0] raddr0,
  output logic [WIDTH-1:0]  rdata0,
  input  logic              re1,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [WIDTH-1:0]  rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re0) begin
      rdata0 <= mem[raddr0];
    end
    if (re1) begin
      rdata1 <= mem[raddr1];
    end
  end

endmodule

@@ design/iasort_ctrl.sv @@
// ----------------------------------------------------------------------------
// iasort_ctrl
// Sequencer: loads the set, runs a quicksort with a middle pivot and an
// explicit partition stack over one shared comparator, then streams the
// sorted set out through an output register.
// ----------------------------------------------------------------------------
module iasort_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  iasort_pkg::in_req_t                in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output iasort_pkg::out_req_t               out_data,
  output logic                               ram_we,
  output logic [iasort_pkg::IDX_W-1:0]       ram_waddr,
  output logic [iasort_pkg::DATA_W-1:0]      ram_wdata,
  output logic                               ram_re0,
  output logic [iasort_pkg::IDX_W-1:0]       ram_raddr0,
  input  logic [iasort_pkg::DATA_W-1:0]      ram_rdata0,
  output logic                               ram_re1,
  output logic [iasort_pkg::IDX_W-1:0]       ram_raddr1,
  input  logic [iasort_pkg::DATA_W-1:0]      ram_rdata1
);
  import iasort_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [SP_W-1:0]    sp_r, sp_nxt;
  logic [IDX_W-1:0]   lo_r, lo_nxt;
  logic [IDX_W-1:0]   hi_r, hi_nxt;
  logic [IDX_W-1:0]   mid_r, mid_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [DATA_W-1:0]  pivot_r, pivot_nxt;
  logic [DATA_W-1:0]  tmp_r, tmp_nxt;
  out_req_t           out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  range_t             stack_mem [STACK_DEPTH];
  range_t             stack_rd_r;
  logic               stack_we;
  logic [IDX_W-1:0]   stack_waddr;
  range_t             stack_wdata;
  logic               stack_re;
  logic [IDX_W-1:0]   stack_raddr;

  logic [CNT_W-1:0]   n_load;
  logic [IDX_W:0]     mid_sum;
  logic               j_at_end;
  logic               out_free;
  logic               out_last;

  // partition stack
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    if (stack_re) begin
      stack_rd_r <= stack_mem[stack_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    pivot_r <= pivot_nxt;
    tmp_r   <= tmp_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    sp_nxt        = sp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    pivot_nxt     = pivot_r;
    tmp_nxt       = tmp_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    ram_we        = 1'b0;
    ram_waddr     = i_r;
    ram_wdata     = pivot_r;
    ram_re0       = 1'b0;
    ram_raddr0    = j_r;
    ram_re1       = 1'b0;
    ram_raddr1    = i_r;

    stack_we      = 1'b0;
    stack_waddr   = sp_r[IDX_W-1:0];
    stack_wdata   = '{lo: lo_r, hi: i_r - IDX_W'(1)};
    stack_re      = 1'b0;
    stack_raddr   = IDX_W'(sp_r - SP_W'(1));

    n_load   = (count_r < CNT_W'(CAPACITY)) ? count_r + CNT_W'(1) : count_r;
    mid_sum  = {1'b0, stack_rd_r.lo} + {1'b0, stack_rd_r.hi};
    j_at_end = ({1'b0, j_r} + (IDX_W+1)'(1)) == {1'b0, hi_r};
    out_free = !out_valid_r || !out_stall;
    out_last = {1'b0, k_r} == (count_r - CNT_W'(1));

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (count_r < CNT_W'(CAPACITY)) begin
            ram_we    = 1'b1;
            ram_waddr = count_r[IDX_W-1:0];
            ram_wdata = in_data.value;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            k_nxt = '0;
            if (n_load >= CNT_W'(2)) begin
              stack_we    = 1'b1;
              stack_waddr = '0;
              stack_wdata = '{lo: '0, hi: IDX_W'(n_load - CNT_W'(1))};
              sp_nxt      = SP_W'(1);
              state_nxt   = S_POP_RD;
            end else begin
              state_nxt = S_OUT_RD;
            end
          end
        end
      end
      S_POP_RD: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else begin
          stack_re  = 1'b1;
          sp_nxt    = sp_r - SP_W'(1);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        lo_nxt     = stack_rd_r.lo;
        hi_nxt     = stack_rd_r.hi;
        mid_nxt    = mid_sum[IDX_W:1];
        ram_re0    = 1'b1;
        ram_raddr0 = mid_sum[IDX_W:1];
        ram_re1    = 1'b1;
        ram_raddr1 = stack_rd_r.hi;
        state_nxt  = S_PIV;
      end
      S_PIV: begin
        // pivot moves to the top of the range
        pivot_nxt = ram_rdata0;
        ram_we    = 1'b1;
        ram_waddr = mid_r;
        ram_wdata = ram_rdata1;
        i_nxt     = lo_r;
        j_nxt     = lo_r;
        state_nxt = S_PIV2;
      end
      S_PIV2: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = pivot_r;
        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        ram_re0    = 1'b1;
        ram_raddr0 = j_r;
        ram_re1    = 1'b1;
        ram_raddr1 = i_r;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        if ($signed(ram_rdata0) < $signed(pivot_r)) begin
          ram_we    = 1'b1;
          ram_waddr = i_r;
          ram_wdata = ram_rdata0;
          tmp_nxt   = ram_rdata1;
          state_nxt = S_SWAP2;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = j_at_end ? S_FIN_RD : S_SCAN_RD;
        end
      end
      S_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = tmp_r;
        i_nxt     = i_r + IDX_W'(1);
        j_nxt     = j_r + IDX_W'(1);
        state_nxt = j_at_end ? S_FIN_RD : S_SCAN_RD;
      end
      S_FIN_RD: begin
        ram_re0    = 1'b1;
        ram_raddr0 = i_r;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = ram_rdata0;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = pivot_r;
        state_nxt = S_PUSH_L;
      end
      S_PUSH_L: begin
        if ({1'b0, i_r} > ({1'b0, lo_r} + (IDX_W+1)'(1))) begin
          stack_we    = 1'b1;
          stack_wdata = '{lo: lo_r, hi: i_r - IDX_W'(1)};
          sp_nxt      = sp_r + SP_W'(1);
        end
        state_nxt = S_PUSH_R;
      end
      S_PUSH_R: begin
        if (({1'b0, i_r} + (IDX_W+1)'(1)) < {1'b0, hi_r}) begin
          stack_we    = 1'b1;
          stack_wdata = '{lo: i_r + IDX_W'(1), hi: hi_r};
          sp_nxt      = sp_r + SP_W'(1);
        end
        state_nxt = S_POP_RD;
      end
      S_OUT_RD: begin
        ram_re0    = 1'b1;
        ram_raddr0 = k_r;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_nxt.sorted_value = $signed(ram_rdata0);
          out_nxt.last_result  = out_last;
          out_nxt.truncated    = ovf_r;
          out_valid_nxt        = 1'b1;
          if (out_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ design/integer_array_sorter.sv @@
// ----------------------------------------------------------------------------
// integer_array_sorter
// Requests are taken one per cycle while loading; after the final request each partition
// is scanned element by element, with the swap state added for each element swapped, all
// through one comparator and one two-read RAM. Results then leave one at a time, each read
// through a single RAM read port and registered once the output register is free.
// Reset (rst_n low, synchronous) empties the set and the partition stack.
// ----------------------------------------------------------------------------
module integer_array_sorter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  iasort_pkg::in_req_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output iasort_pkg::out_req_t  out_data
);
  import iasort_pkg::*;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re0;
  logic [IDX_W-1:0]  ram_raddr0;
  logic [DATA_W-1:0] ram_rdata0;
  logic              ram_re1;
  logic [IDX_W-1:0]  ram_raddr1;
  logic [DATA_W-1:0] ram_rdata1;

  iasort_ram #(
    .WIDTH  (DATA_W),
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re0    (ram_re0),
    .raddr0 (ram_raddr0),
    .rdata0 (ram_rdata0),
    .re1    (ram_re1),
    .raddr1 (ram_raddr1),
    .rdata1 (ram_rdata1)
  );

  iasort_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re0    (ram_re0),
    .ram_raddr0 (ram_raddr0),
    .ram_rdata0 (ram_rdata0),
    .ram_re1    (ram_re1),
    .ram_raddr1 (ram_raddr1),
    .ram_rdata1 (ram_rdata1)
  );

endmodule

@@ design/iasort_checker.sv @@
// ----------------------------------------------------------------------------
// iasort_checker
// Port-level checks on the integer array sorter, bound to the top level.
// ----------------------------------------------------------------------------
module iasort_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input iasort_pkg::in_req_t   in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input iasort_pkg::out_req_t  out_data
);
  import iasort_pkg::*;

  // ready for a new set straight after reset
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // final request ends loading, no request taken next cycle
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_item |=> in_stall)
    else $error("request taken during sort");

  // nothing comes out unless sorting or draining
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared while loading");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind integer_array_sorter iasort_checker u_iasort_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
